// File: rtl/sample_playhead_position_table_core_assert.svh
// Assertion macros shared by the playhead position table RTL.
`ifndef SAMPLE_PLAYHEAD_POSITION_TABLE_CORE_ASSERT_SVH
`define SAMPLE_PLAYHEAD_POSITION_TABLE_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPPTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPPTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spptc_pkg.sv
// Package with constants and codes for the playhead position table.
`timescale 1ns / 1ps

package spptc_pkg;

    localparam int ENTITY_COUNT  = 16;
    localparam int FRACTION_BITS = 16;

    localparam int ENTITY_W    = 8;
    localparam int TIME_W      = 64;
    localparam int DUR_W       = 32;
    localparam int MODE_W      = 2;
    localparam int POSITION_W  = 17;
    localparam int ENT_IDX_W   = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
    localparam int QUO_W       = FRACTION_BITS + 1;
    localparam int CNT_W       = $clog2(TIME_W);
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 24;

    localparam logic ACTION_TRIGGER = 1'b0;
    localparam logic ACTION_QUERY   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PING    = 2'd3;

endpackage

// File: rtl/spptc_table.sv
// Start time table with one write port and one read port, cleared at reset.
`timescale 1ns / 1ps

module spptc_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [spptc_pkg::ENT_IDX_W-1:0]      wr_idx,
    input  logic [spptc_pkg::TIME_W-1:0]         wr_data,
    input  logic [spptc_pkg::ENT_IDX_W-1:0]      rd_idx,
    output logic [spptc_pkg::TIME_W-1:0]         rd_data
);

    logic [spptc_pkg::TIME_W-1:0] start_reg [spptc_pkg::ENTITY_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spptc_pkg::ENTITY_COUNT; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            start_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = start_reg[rd_idx];

endmodule

// File: rtl/spptc_divstep.sv
// Shared compare and subtract step of the bit-serial divider.
`timescale 1ns / 1ps

module spptc_divstep (
    input  logic [spptc_pkg::DUR_W:0]    a,
    input  logic [spptc_pkg::DUR_W-1:0]  d,
    output logic                         ge,
    output logic [spptc_pkg::DUR_W-1:0]  res
);

    logic [spptc_pkg::DUR_W+1:0] diff;

    assign diff = {1'b0, a} - {2'b00, d};
    assign ge   = !diff[spptc_pkg::DUR_W+1];
    assign res  = ge ? diff[spptc_pkg::DUR_W-1:0] : a[spptc_pkg::DUR_W-1:0];

endmodule

// File: rtl/sample_playhead_position_table_core.sv
// Top level of the playhead position table: handshakes, sequencer and result register.
`timescale 1ns / 1ps

// A trigger word with an in-range entity stores its time plus one for the voice as it is taken.
// A query word keeps the block busy through the setup steps (look, subtract and check)
// and a 64-step remainder pass. A fold step then folds the remainder for
// the reverse and ping-pong modes, and a FRACTION_BITS + 1 step fraction pass follows.
// Both passes go through the one shared compare and subtract unit. A final step loads
// the result register. Queries found inactive during setup skip straight to the final
// step. The final step waits while an earlier result is still held in the result
// register. The result register lets a new word be taken while a result waits.

module sample_playhead_position_table_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entity[7:0], sample_time[71:8], duration[103:72], play_mode[105:104], zero fill
    input  logic [spptc_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position[16:0], zero fill
    output logic [spptc_pkg::M_TDATA_W-1:0]     m_tdata,
    // active[0]
    output logic                                m_tuser
);

    `include "sample_playhead_position_table_core_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_PREP = 3'd5;
    localparam logic [2:0] ST_DIV2 = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                              state_reg, state_next;
    logic [spptc_pkg::ENTITY_W-1:0]          entity_reg, entity_next;
    logic [spptc_pkg::TIME_W-1:0]            now_reg, now_next;
    logic [spptc_pkg::DUR_W-1:0]             dur_reg, dur_next;
    logic [spptc_pkg::MODE_W-1:0]            mode_reg, mode_next;
    logic [spptc_pkg::TIME_W-1:0]            start_reg, start_next;
    logic [spptc_pkg::TIME_W-1:0]            elapsed_reg, elapsed_next;
    logic [spptc_pkg::DUR_W-1:0]             rem_reg, rem_next;
    logic [spptc_pkg::QUO_W-1:0]             quo_reg, quo_next;
    logic [spptc_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic                                    active_reg, active_next;
    logic                                    odd_reg, odd_next;
    logic                                    out_valid_reg, out_valid_next;
    logic                                    out_active_reg, out_active_next;
    logic [spptc_pkg::POSITION_W-1:0]        out_pos_reg, out_pos_next;

    logic                                    in_accept;
    logic                                    in_range_s;
    logic                                    in_range_q;
    logic                                    tbl_wr_en;
    logic [spptc_pkg::TIME_W-1:0]            tbl_rd_data;
    logic [spptc_pkg::TIME_W:0]              sub_diff;
    logic [spptc_pkg::DUR_W:0]               div_a;
    logic                                    div_ge;
    logic [spptc_pkg::DUR_W-1:0]             div_res;
    logic                                    back_half;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign in_range_s = ({1'b0, s_tdata[7:0]} < 9'(spptc_pkg::ENTITY_COUNT));
    assign in_range_q = ({1'b0, entity_reg} < 9'(spptc_pkg::ENTITY_COUNT));
    assign tbl_wr_en  = in_accept && (s_tuser == spptc_pkg::ACTION_TRIGGER) && in_range_s;

    spptc_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_idx  (s_tdata[spptc_pkg::ENT_IDX_W-1:0]),
        .wr_data (s_tdata[71:8] + 64'd1),
        .rd_idx  (entity_reg[spptc_pkg::ENT_IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    assign sub_diff = {1'b0, now_reg} - {1'b0, start_reg};

    always_comb
    begin
        if (state_reg == ST_DIV1)
        begin
            div_a = {rem_reg, elapsed_reg[spptc_pkg::TIME_W-1]};
        end
        else if (cnt_reg == '0)
        begin
            div_a = {1'b0, rem_reg};
        end
        else
        begin
            div_a = {rem_reg, 1'b0};
        end
    end

    spptc_divstep u_divstep (
        .a   (div_a),
        .d   (dur_reg),
        .ge  (div_ge),
        .res (div_res)
    );

    assign back_half = (mode_reg == spptc_pkg::MODE_REVERSE) ||
                       ((mode_reg == spptc_pkg::MODE_PING) && odd_reg);

    always_comb
    begin
        state_next      = state_reg;
        entity_next     = entity_reg;
        now_next        = now_reg;
        dur_next        = dur_reg;
        mode_next       = mode_reg;
        start_next      = start_reg;
        elapsed_next    = elapsed_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        odd_next        = odd_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_active_next = out_active_reg;
        out_pos_next    = out_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == spptc_pkg::ACTION_QUERY))
                begin
                    entity_next = s_tdata[7:0];
                    now_next    = s_tdata[71:8];
                    dur_next    = s_tdata[103:72];
                    mode_next   = s_tdata[105:104];
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!in_range_q || (dur_reg == '0) || (tbl_rd_data == '0))
                begin
                    active_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    start_next = tbl_rd_data - 64'd1;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (sub_diff[spptc_pkg::TIME_W])
                begin
                    active_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    elapsed_next = sub_diff[spptc_pkg::TIME_W-1:0];
                    state_next   = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (((mode_reg == spptc_pkg::MODE_FORWARD) ||
                     (mode_reg == spptc_pkg::MODE_REVERSE)) &&
                    ((elapsed_reg[63:32] != '0) || (elapsed_reg[31:0] >= dur_reg)))
                begin
                    active_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                rem_next     = div_res;
                elapsed_next = {elapsed_reg[spptc_pkg::TIME_W-2:0], 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == spptc_pkg::CNT_W'(spptc_pkg::TIME_W - 1))
                begin
                    odd_next   = div_ge;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                rem_next   = back_half ? (dur_reg - rem_reg) : rem_reg;
                cnt_next   = '0;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                rem_next = div_res;
                quo_next = {quo_reg[spptc_pkg::QUO_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == spptc_pkg::CNT_W'(spptc_pkg::FRACTION_BITS))
                begin
                    active_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_active_next = active_reg;
                    out_pos_next    = active_reg ? spptc_pkg::POSITION_W'(quo_reg) : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entity_reg     <= entity_next;
        now_reg        <= now_next;
        dur_reg        <= dur_next;
        mode_reg       <= mode_next;
        start_reg      <= start_next;
        elapsed_reg    <= elapsed_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        odd_reg        <= odd_next;
        out_active_reg <= out_active_next;
        out_pos_reg    <= out_pos_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_active_reg;
    assign m_tdata  = {{(spptc_pkg::M_TDATA_W - spptc_pkg::POSITION_W){1'b0}}, out_pos_reg};

    `SPPTC_ASSERT_IMP(a_inactive_zero_pos, m_tvalid && !m_tuser, m_tdata == '0, "Inactive word with nonzero position.")
    `SPPTC_ASSERT_NXT(a_query_blocks_input, s_tvalid && s_tready && (s_tuser == spptc_pkg::ACTION_QUERY), !s_tready, "Input taken while a query is in progress.")
    `SPPTC_ASSERT_IMP(a_result_from_done, $rose(m_tvalid), $past(state_reg) == ST_DONE, "Result word raised outside the final step.")

endmodule
